>>> src/sts_pkg.sv
// Shared types and constants for the stencil-to-sparse-triplet block.
// No dependencies; imported by the channel interfaces, the top level and the checker.
package sts_pkg;

    localparam int IDX_W         = 18;  // grid point index
    localparam int ROW_W         = 19;  // one-based row and column numbers
    localparam int TAP_BITS      = 4;
    localparam int COEF_W        = 16;  // coefficient word on the port
    localparam int KIND_W        = 2;
    localparam int GRID_SIDE_W   = 7;
    localparam int NUM_TAPS      = 9;
    localparam int TAPS_PER_REG  = 4;   // coefficient words packed in one 64-bit register
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = GRID_SIDE_W'(64);

    typedef enum logic [KIND_W-1:0] {
        KIND_1D3 = 2'd0,
        KIND_2D5 = 2'd1,
        KIND_2D9 = 2'd2,
        KIND_3D7 = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STENCIL_KIND = 3'd0,
        CFG_GRID_SIDE    = 3'd1,
        CFG_REAL_0_3     = 3'd2,
        CFG_REAL_4_7     = 3'd3,
        CFG_REAL_8       = 3'd4,
        CFG_IMAG_0_3     = 3'd5,
        CFG_IMAG_4_7     = 3'd6,
        CFG_IMAG_8       = 3'd7
    } t_cfg_idx;

endpackage

>>> src/sts_row_if.sv
// Input channel: one grid point index per item, valid/ready handshake.
// Depends on sts_pkg.
interface sts_row_if import sts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;

    modport source (output valid, output row_index, input ready);
    modport sink   (input valid, input row_index, output ready);
endinterface

>>> src/sts_trip_if.sv
// Output channel: one sparse matrix triplet per item, valid/ready handshake.
// Depends on sts_pkg.
interface sts_trip_if import sts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_W-1:0]    row_number;
    logic [ROW_W-1:0]    col_number;
    logic [TAP_BITS-1:0] tap;
    logic [COEF_W-1:0]   coef_real;
    logic [COEF_W-1:0]   coef_imag;
    logic                last;
    logic                row_out_of_range;

    modport source (output valid, output row_number, output col_number, output tap,
                    output coef_real, output coef_imag, output last,
                    output row_out_of_range, input ready);
    modport sink   (input valid, input row_number, input col_number, input tap,
                    input coef_real, input coef_imag, input last,
                    input row_out_of_range, output ready);
endinterface

>>> src/stencil_to_sparse_triplets.sv
// Stencil to sparse COO triplet generator, top level.
// Depends on sts_pkg, sts_row_if and sts_trip_if.
//
// Each row index item produces 1 to 9 triplets, one per cycle on the result
// channel while it is ready (at most 3, 5, 9 or 7 by stencil kind; one for an
// out-of-range index). The result port's one-triplet-per-cycle rate sets the
// throughput; a new row index is accepted every cycle as long as the pipeline
// has room. The x/y/z split is a pipelined restoring divider, 4 quotient bits
// per stage over 2*18 bits. After a grid_side or stencil_kind write the
// derived sizes are registered anew in r_side, r_nn and r_count in turn.
module stencil_to_sparse_triplets import sts_pkg::*; #(
    parameter int MAX_SIDE  = 64,
    parameter int COEF_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    sts_row_if.sink               i_row,
    sts_trip_if.source            o_trip
);

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int SW1        = SIDE_W + 1;
    localparam int NN_W       = 2 * SIDE_W;
    localparam int CNT_W      = 3 * SIDE_W;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int SAT_W      = (SIDE_W > GRID_SIDE_W) ? SIDE_W : GRID_SIDE_W;
    localparam int ZW         = IDX_W + 1;
    localparam int STEPS      = 4;
    localparam int DIV_STEPS  = 2 * IDX_W;
    localparam int NSTG       = (DIV_STEPS + STEPS - 1) / STEPS;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  dvd;
        logic [IDX_W-1:0]  quot;
        logic [SIDE_W-1:0] rem;
        logic [SIDE_W-1:0] x;
    } t_div;

    typedef enum logic [TAP_BITS-1:0] {
        TAP_CTR = 4'd0,
        TAP_WST = 4'd1,
        TAP_EST = 4'd2,
        TAP_3   = 4'd3,   // S, or SW on the 9-point stencil
        TAP_4   = 4'd4,   // N, or S
        TAP_5   = 4'd5,   // down, or SE
        TAP_6   = 4'd6,   // up, or NW
        TAP_7   = 4'd7,
        TAP_8   = 4'd8
    } t_tap;

    // configuration
    t_kind                r_kind;
    logic [GRID_SIDE_W-1:0] r_grid_side;
    logic [COEF_BITS-1:0] r_re [NUM_TAPS];
    logic [COEF_BITS-1:0] r_im [NUM_TAPS];

    // sizes derived from the configuration
    logic [SIDE_W-1:0] r_side;
    logic [SIDE_W-1:0] n_side;
    logic [NN_W-1:0]   r_nn;
    logic [CNT_W-1:0]  r_count;
    logic [ROW_W-1:0]  r_np1;
    logic [ROW_W-1:0]  r_nm1;

    // divider pipeline, stage 0 is the input register
    logic        r_v   [NSTG+1];
    t_div        r_div [NSTG+1];
    t_div        n_div [NSTG+1];
    logic        free  [NSTG+1];

    // classify stage
    logic                r_c_v;
    logic [NUM_TAPS-1:0] r_c_mask;
    logic                r_c_oor;
    logic [ROW_W-1:0]    r_c_row;
    logic [NUM_TAPS-1:0] n_c_mask;
    logic                n_c_oor;

    // expander stage
    logic                r_e_v;
    logic [NUM_TAPS-1:0] r_e_mask;
    logic                r_e_oor;
    logic [ROW_W-1:0]    r_e_row;

    // output register
    logic                r_o_v;
    logic [ROW_W-1:0]    r_o_row;
    logic [ROW_W-1:0]    r_o_col;
    t_tap                r_o_tap;
    logic [COEF_W-1:0]   r_o_re;
    logic [COEF_W-1:0]   r_o_im;
    logic                r_o_last;
    logic                r_o_oor;

    logic                en_o;
    logic                e_last;
    logic                e_free;
    logic                c_free;
    t_tap                sel_tap;
    logic [NUM_TAPS-1:0] e_rest;
    logic [ROW_W-1:0]    off_mag;
    logic                off_sub;
    logic [ROW_W-1:0]    n_o_col;

    function automatic t_div div_stage(input t_div s_in, input int base,
                                       input logic [SIDE_W-1:0] side);
        t_div         s;
        logic [SW1-1:0] t;
        logic         ge;
        int           gs;
        int           j;
        s = s_in;
        for (j = 0; j < STEPS; j++) begin
            gs = base + j;
            // first division done: keep x, divide the quotient again
            if (gs == IDX_W) begin
                s.x    = s.rem;
                s.dvd  = s.quot;
                s.quot = '0;
                s.rem  = '0;
            end
            if (gs < DIV_STEPS) begin
                t      = {s.rem, s.dvd[IDX_W-1]};
                ge     = (t >= {1'b0, side});
                s.rem  = ge ? SIDE_W'(t - {1'b0, side}) : t[SIDE_W-1:0];
                s.dvd  = {s.dvd[IDX_W-2:0], 1'b0};
                s.quot = {s.quot[IDX_W-2:0], ge};
            end
        end
        return s;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_2D5;
            r_grid_side <= GRID_SIDE_RST;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_re[i] <= '0;
                r_im[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STENCIL_KIND: r_kind <= t_kind'(i_cfg_wdata[KIND_W-1:0]);
                CFG_GRID_SIDE:    r_grid_side <= i_cfg_wdata[GRID_SIDE_W-1:0];
                CFG_REAL_0_3: begin
                    for (int w = 0; w < TAPS_PER_REG; w++)
                        r_re[w] <= i_cfg_wdata[COEF_W*w +: COEF_BITS];
                end
                CFG_REAL_4_7: begin
                    for (int w = 0; w < TAPS_PER_REG; w++)
                        r_re[TAPS_PER_REG+w] <= i_cfg_wdata[COEF_W*w +: COEF_BITS];
                end
                CFG_REAL_8:   r_re[NUM_TAPS-1] <= i_cfg_wdata[COEF_BITS-1:0];
                CFG_IMAG_0_3: begin
                    for (int w = 0; w < TAPS_PER_REG; w++)
                        r_im[w] <= i_cfg_wdata[COEF_W*w +: COEF_BITS];
                end
                CFG_IMAG_4_7: begin
                    for (int w = 0; w < TAPS_PER_REG; w++)
                        r_im[TAPS_PER_REG+w] <= i_cfg_wdata[COEF_W*w +: COEF_BITS];
                end
                CFG_IMAG_8:   r_im[NUM_TAPS-1] <= i_cfg_wdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // side saturates at MAX_SIDE
    always_comb begin
        if (SAT_W'(r_grid_side) > SAT_W'(MAX_SIDE)) begin
            n_side = SIDE_W'(MAX_SIDE);
        end else begin
            n_side = SIDE_W'(r_grid_side);
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_nn   <= NN_W'(r_side) * NN_W'(r_side);
        r_np1  <= ROW_W'(r_side) + ROW_W'(1);
        r_nm1  <= ROW_W'(r_side) - ROW_W'(1);
        case (r_kind)
            KIND_1D3: r_count <= CNT_W'(r_side);
            KIND_3D7: r_count <= CNT_W'(r_nn) * CNT_W'(r_side);
            default:  r_count <= CNT_W'(r_nn);
        endcase
    end

    // ---------------- flow control ----------------
    assign en_o   = !r_o_v || o_trip.ready;
    assign e_free = !r_e_v || (en_o && e_last);
    assign c_free = !r_c_v || e_free;

    always_comb begin
        free[NSTG] = !r_v[NSTG] || c_free;
        for (int k = NSTG - 1; k >= 0; k--) begin
            free[k] = !r_v[k] || free[k+1];
        end
    end

    assign i_row.ready = free[0];

    // ---------------- divider pipeline ----------------
    always_comb begin
        n_div[0].idx  = i_row.row_index;
        n_div[0].dvd  = i_row.row_index;
        n_div[0].quot = '0;
        n_div[0].rem  = '0;
        n_div[0].x    = '0;
        for (int k = 1; k <= NSTG; k++) begin
            n_div[k] = div_stage(r_div[k-1], (k - 1) * STEPS, r_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTG; k++) r_v[k] <= 1'b0;
        end else begin
            if (free[0]) r_v[0] <= i_row.valid;
            for (int k = 1; k <= NSTG; k++) begin
                if (free[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NSTG; k++) begin
            if (free[k]) r_div[k] <= n_div[k];
        end
    end

    // ---------------- classify: range check and tap mask ----------------
    always_comb begin
        logic           w_ok;
        logic           e_ok;
        logic           s_ok;
        logic           n_ok;
        logic           d_ok;
        logic           u_ok;
        logic [SIDE_W-1:0] y;
        y    = r_div[NSTG].rem;
        w_ok = (r_div[NSTG].x != '0);
        e_ok = (SW1'(r_div[NSTG].x) + SW1'(1)) < SW1'(r_side);
        s_ok = (y != '0);
        n_ok = (SW1'(y) + SW1'(1)) < SW1'(r_side);
        d_ok = (r_div[NSTG].quot != '0);
        u_ok = (ZW'(r_div[NSTG].quot) + ZW'(1)) < ZW'(r_side);
        n_c_oor = (r_side == '0) || (CMP_W'(r_div[NSTG].idx) >= CMP_W'(r_count));

        n_c_mask          = '0;
        n_c_mask[TAP_CTR] = 1'b1;
        n_c_mask[TAP_WST] = w_ok;
        n_c_mask[TAP_EST] = e_ok;
        case (r_kind)
            KIND_2D5: begin
                n_c_mask[TAP_3] = s_ok;
                n_c_mask[TAP_4] = n_ok;
            end
            KIND_3D7: begin
                n_c_mask[TAP_3] = s_ok;
                n_c_mask[TAP_4] = n_ok;
                n_c_mask[TAP_5] = d_ok;
                n_c_mask[TAP_6] = u_ok;
            end
            KIND_2D9: begin
                n_c_mask[TAP_3] = s_ok && w_ok;
                n_c_mask[TAP_4] = s_ok;
                n_c_mask[TAP_5] = s_ok && e_ok;
                n_c_mask[TAP_6] = n_ok && w_ok;
                n_c_mask[TAP_7] = n_ok;
                n_c_mask[TAP_8] = n_ok && e_ok;
            end
            default: ;
        endcase
        // out of range: one item on the center slot
        if (n_c_oor) begin
            n_c_mask          = '0;
            n_c_mask[TAP_CTR] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (c_free) begin
            r_c_v <= r_v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free) begin
            r_c_mask <= n_c_mask;
            r_c_oor  <= n_c_oor;
            r_c_row  <= ROW_W'(r_div[NSTG].idx) + ROW_W'(1);
        end
    end

    // ---------------- expander: one triplet per cycle ----------------
    always_comb begin
        sel_tap = TAP_CTR;
        for (int i = NUM_TAPS - 1; i >= 0; i--) begin
            if (r_e_mask[i]) sel_tap = t_tap'(TAP_BITS'(i));
        end
        e_rest = r_e_mask & ~(NUM_TAPS'(1) << sel_tap);
        e_last = (e_rest == '0);
    end

    always_comb begin
        off_mag = '0;
        off_sub = 1'b0;
        case (sel_tap)
            TAP_CTR: off_mag = '0;
            TAP_WST: begin
                off_mag = ROW_W'(1);
                off_sub = 1'b1;
            end
            TAP_EST: off_mag = ROW_W'(1);
            TAP_3: begin
                off_mag = (r_kind == KIND_2D9) ? r_np1 : ROW_W'(r_side);
                off_sub = 1'b1;
            end
            TAP_4: begin
                off_mag = ROW_W'(r_side);
                off_sub = (r_kind == KIND_2D9);
            end
            TAP_5: begin
                off_mag = (r_kind == KIND_2D9) ? r_nm1 : ROW_W'(r_nn);
                off_sub = 1'b1;
            end
            TAP_6: off_mag = (r_kind == KIND_2D9) ? r_nm1 : ROW_W'(r_nn);
            TAP_7: off_mag = ROW_W'(r_side);
            TAP_8: off_mag = r_np1;
            default: off_mag = '0;
        endcase
        n_o_col = off_sub ? (r_e_row - off_mag) : (r_e_row + off_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (e_free) begin
            r_e_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_free) begin
            r_e_mask <= r_c_mask;
            r_e_oor  <= r_c_oor;
            r_e_row  <= r_c_row;
        end else if (en_o && r_e_v) begin
            r_e_mask <= e_rest;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_o) begin
            r_o_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_e_v) begin
            r_o_row  <= r_e_row;
            r_o_tap  <= sel_tap;
            r_o_last <= e_last;
            r_o_oor  <= r_e_oor;
            if (r_e_oor) begin
                r_o_col <= '0;
                r_o_re  <= '0;
                r_o_im  <= '0;
            end else begin
                r_o_col <= n_o_col;
                r_o_re  <= COEF_W'(r_re[sel_tap]);
                r_o_im  <= COEF_W'(r_im[sel_tap]);
            end
        end
    end

    assign o_trip.valid            = r_o_v;
    assign o_trip.row_number       = r_o_row;
    assign o_trip.col_number       = r_o_col;
    assign o_trip.tap              = r_o_tap;
    assign o_trip.coef_real        = r_o_re;
    assign o_trip.coef_imag        = r_o_im;
    assign o_trip.last             = r_o_last;
    assign o_trip.row_out_of_range = r_o_oor;

endmodule

>>> src/sts_checker.sv
// Port-level checks for stencil_to_sparse_triplets, bound to the top level.
// Depends on sts_pkg.
module sts_checker import sts_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [ROW_W-1:0]    i_row_number,
    input logic [ROW_W-1:0]    i_col_number,
    input logic [TAP_BITS-1:0] i_tap,
    input logic                i_last,
    input logic                i_oor
);

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row_number)
            && $stable(i_col_number) && $stable(i_tap))
        else $error("stalled triplet changed");

    // an out-of-range row is a single marked item on the center slot
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_oor |-> i_last && (i_tap == '0) && (i_col_number == '0))
        else $error("out-of-range item malformed");

    // the center tap sits on the diagonal
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_oor && (i_tap == '0) |-> i_col_number == i_row_number)
        else $error("center tap off the diagonal");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind stencil_to_sparse_triplets sts_checker u_sts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_trip.valid),
    .i_out_ready  (o_trip.ready),
    .i_row_number (o_trip.row_number),
    .i_col_number (o_trip.col_number),
    .i_tap        (o_trip.tap),
    .i_last       (o_trip.last),
    .i_oor        (o_trip.row_out_of_range)
);
